FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// command and status codes plus request/response widths for the list engine
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_READ   = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_BADPOS   = 3'd1,
      STS_FULL     = 3'd2,
      STS_NOTFOUND = 3'd3,
      STS_EMPTY    = 3'd4
   } status_type;

endpackage

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered byte list with append, positional insert/delete/read, locate and clear
// ----------------------------------------------------------------------------
// append, clear and rejected requests go straight to the done state; read
//   passes S_RD and S_RD_WAIT; insert walks from the tail back to the target,
//   delete from the target to the tail, locate from the head to a match or the
//   end; one request at a time, the element memory walked one entry per cycle
// a new request is taken while the previous response still waits
// reset clears the length and the handshake state; memory is not cleared
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] cmd, [10:3] position, [18:11] value, [23:19] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] status, [10:3] element, [18:11] found_at, [26:19] length,
   // [27] is_empty, [31:28] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);   // count width
   localparam int AW = $clog2(CAPACITY);       // memory address width

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_INS_FIN, S_DEL, S_DEL_END, S_RD, S_RD_WAIT, S_LOC, S_DONE
   } state_type;

   // request fields
   logic [2:0] req_cmd;
   logic [7:0] req_position;
   logic [7:0] req_value;
   assign req_cmd      = req_tdata[2:0];
   assign req_position = req_tdata[10:3];
   assign req_value    = req_tdata[18:11];

   state_type  state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] tgt_ff;
   logic [CW-1:0] cmp_idx_ff;
   logic [7:0]    val_ff;
   logic          wr_pend_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          cap_ff;
   logic          cmp_pend_ff;
   logic [7:0]    rd_data_ff;
   status_type    status_ff;
   logic [7:0]    elem_ff;
   logic [7:0]    found_ff;
   logic          rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // element store, one write and one registered read per cycle
   logic [7:0]    mem [CAPACITY];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   logic          req_take;
   logic          hit;
   logic [CW-1:0] idx_m1;
   logic [CW-1:0] req_tgt;
   logic          pos_zero;
   logic          pos_gt_count;
   logic          pos_gt_count_p1;
   logic          is_full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign idx_m1          = idx_ff - 1'b1;
   assign req_tgt         = CW'(req_position - 8'd1);
   assign pos_zero        = (req_position == 8'd0);
   assign pos_gt_count    = {1'b0, req_position} > 9'(count_ff);
   assign pos_gt_count_p1 = {1'b0, req_position} > (9'(count_ff) + 9'd1);
   assign is_full         = (count_ff == CW'(CAPACITY));
   // compare result of the entry read in the previous cycle
   assign hit             = cmp_pend_ff && (rd_data_ff == val_ff);

   // memory port steering: pending shift writes by default
   always_comb begin
      mem_we    = wr_pend_ff;
      mem_waddr = wr_addr_ff;
      mem_wdata = rd_data_ff;
      mem_re    = 1'b0;
      mem_raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            // append writes straight into the tail slot
            if (req_take && (cmd_type'(req_cmd) == CMD_APPEND) && !is_full) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[AW-1:0];
               mem_wdata = req_value;
            end
         end
         S_INS: begin
            // walk from the tail toward the target, one entry back per cycle
            if (idx_ff != tgt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_m1[AW-1:0];
            end
         end
         S_INS_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff[AW-1:0];
            mem_wdata = val_ff;
         end
         S_DEL: begin
            mem_re = 1'b1;
         end
         S_RD: begin
            mem_re    = 1'b1;
            mem_raddr = tgt_ff[AW-1:0];
         end
         S_LOC: begin
            if (!hit && (idx_ff < count_ff)) begin
               mem_re = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         wr_pend_ff    <= 1'b0;
         cap_ff        <= 1'b0;
         cmp_pend_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         wr_pend_ff  <= 1'b0;
         cap_ff      <= 1'b0;
         cmp_pend_ff <= 1'b0;
         // the done state reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  val_ff    <= req_value;
                  elem_ff   <= 8'd0;
                  found_ff  <= 8'd0;
                  status_ff <= STS_OK;
                  tgt_ff    <= req_tgt;
                  state_ff  <= S_DONE;
                  case (req_cmd)
                     CMD_APPEND: begin
                        if (is_full) begin
                           status_ff <= STS_FULL;
                        end else begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     CMD_INSERT: begin
                        // position checked before fullness
                        if (pos_zero || pos_gt_count_p1) begin
                           status_ff <= STS_BADPOS;
                        end else if (is_full) begin
                           status_ff <= STS_FULL;
                        end else begin
                           idx_ff   <= count_ff;
                           state_ff <= S_INS;
                        end
                     end
                     CMD_DELETE: begin
                        if (pos_zero || pos_gt_count) begin
                           status_ff <= STS_BADPOS;
                        end else begin
                           idx_ff   <= req_tgt;
                           state_ff <= S_DEL;
                        end
                     end
                     CMD_READ: begin
                        if (pos_zero || pos_gt_count) begin
                           status_ff <= STS_BADPOS;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     CMD_LOCATE: begin
                        idx_ff   <= '0;
                        state_ff <= S_LOC;
                     end
                     CMD_CLEAR: begin
                        if (count_ff == '0) begin
                           status_ff <= STS_EMPTY;
                        end else begin
                           count_ff <= '0;
                        end
                     end
                     default: begin
                        // unused codes: no operation
                     end
                  endcase
               end
            end
            S_INS: begin
               // entry idx-1 read now lands in idx next cycle
               if (idx_ff != tgt_ff) begin
                  wr_pend_ff <= 1'b1;
                  wr_addr_ff <= idx_ff[AW-1:0];
                  idx_ff     <= idx_m1;
               end else begin
                  state_ff <= S_INS_FIN;
               end
            end
            S_INS_FIN: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_DEL: begin
               // first read returns the removed byte, later ones move forward
               cap_ff     <= (idx_ff == tgt_ff);
               wr_pend_ff <= (idx_ff != tgt_ff);
               wr_addr_ff <= idx_m1[AW-1:0];
               if (cap_ff) begin
                  elem_ff <= rd_data_ff;
               end
               if (idx_ff == count_ff - 1'b1) begin
                  state_ff <= S_DEL_END;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DEL_END: begin
               if (cap_ff) begin
                  elem_ff <= rd_data_ff;
               end
               count_ff <= count_ff - 1'b1;
               state_ff <= S_DONE;
            end
            S_RD: begin
               state_ff <= S_RD_WAIT;
            end
            S_RD_WAIT: begin
               elem_ff  <= rd_data_ff;
               state_ff <= S_DONE;
            end
            S_LOC: begin
               if (hit) begin
                  found_ff <= 8'(cmp_idx_ff) + 8'd1;
                  state_ff <= S_DONE;
               end else if (idx_ff < count_ff) begin
                  cmp_pend_ff <= 1'b1;
                  cmp_idx_ff  <= idx_ff;
                  idx_ff      <= idx_ff + 1'b1;
               end else if (!cmp_pend_ff) begin
                  status_ff <= STS_NOTFOUND;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               // load the output register once it is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {4'd0, (count_ff == '0), 8'(count_ff),
                                    found_ff, elem_ff, 3'(status_ff)};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // length never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length beyond capacity");

   // shift writes never spill into the next request
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_pend_ff)
      else $error("pending memory write while idle");

   // every read touches a live element
   a_read_live: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (CW'(mem_raddr) < count_ff))
      else $error("memory read beyond list length");

   // writes stay within the list or its new tail slot
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) <= count_ff))
      else $error("memory write beyond list tail");

   // emptiness flag agrees with the reported length
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[27] == (rsp_tdata_ff[26:19] == 8'd0)))
      else $error("empty flag disagrees with length");

endmodule

FILE: bench/positional_list_engine_test.sv
// ----------------------------------------------------------------------------
// positional_list_engine_test
// self-checking bench for the positional byte list engine: a directed pass over
// the corner cases, then random command streams with random idling on both
// sides, a long response hold-off and a back-to-back stretch; every response is
// compared field by field against a behavioral copy of the list
// ----------------------------------------------------------------------------
module positional_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;

   localparam int LIST_CAPACITY = 16;

   // command codes with no defined operation, expected to act as a no-op
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;

   // response fields, laid out exactly as rsp_tdata[27:0]
   typedef struct packed {
      logic       is_empty;
      logic [7:0] length;
      logic [7:0] found_at;
      logic [7:0] element;
      logic [2:0] status;
   } list_result_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [2:0] cmd, [10:3] position, [18:11] value, [23:19] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [2:0] status, [10:3] element, [18:11] found_at, [26:19] length,
   // [27] is_empty, [31:28] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // behavioral copy of the list contents and length
   logic [7:0]   stored_bytes [LIST_CAPACITY];
   int           stored_count = 0;

   // responses still owed by the block, oldest first
   list_result_t pending_results [$];

   int  mismatch_count  = 0;
   bit  sender_idle     = 1'b0;
   bit  receiver_idle   = 1'b0;
   int  hold_off_cycles = 0;
   int  receiver_stall  = 0;
   int  receiver_gap;

   list_result_t want_result;
   list_result_t got_result;

   positional_list_engine #(
      .CAPACITY (LIST_CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // list behavior: applies one command to the copy and returns the response
   // ------------------------------------------------------------------------
   function automatic list_result_t apply_list_command(logic [2:0] cmd,
                                                       logic [7:0] pos,
                                                       logic [7:0] val);
      list_result_t res;
      int           k;
      res = '0;
      res.status = STS_OK;
      case (cmd)
         CMD_APPEND: begin
            if (stored_count >= LIST_CAPACITY) begin
               res.status = STS_FULL;
            end else begin
               stored_bytes[stored_count] = val;
               stored_count++;
            end
         end
         CMD_INSERT: begin
            // position is checked before fullness
            if (pos < 1 || pos > stored_count + 1) begin
               res.status = STS_BADPOS;
            end else if (stored_count >= LIST_CAPACITY) begin
               res.status = STS_FULL;
            end else begin
               // new byte becomes element number pos, the tail moves back
               for (k = stored_count; k > pos - 1; k--)
                  stored_bytes[k] = stored_bytes[k-1];
               stored_bytes[pos-1] = val;
               stored_count++;
            end
         end
         CMD_DELETE: begin
            if (pos < 1 || pos > stored_count) begin
               res.status = STS_BADPOS;
            end else begin
               res.element = stored_bytes[pos-1];
               for (k = pos - 1; k + 1 < stored_count; k++)
                  stored_bytes[k] = stored_bytes[k+1];
               stored_count--;
            end
         end
         CMD_READ: begin
            if (pos < 1 || pos > stored_count)
               res.status = STS_BADPOS;
            else
               res.element = stored_bytes[pos-1];
         end
         CMD_LOCATE: begin
            // first match wins, an empty list never matches
            res.status = STS_NOTFOUND;
            for (k = 0; k < stored_count; k++) begin
               if (stored_bytes[k] == val) begin
                  res.found_at = 8'(k + 1);
                  res.status   = STS_OK;
                  break;
               end
            end
         end
         CMD_CLEAR: begin
            if (stored_count == 0)
               res.status = STS_EMPTY;
            else
               stored_count = 0;
         end
         default: begin
            // spare codes leave the list alone
         end
      endcase
      res.length   = 8'(stored_count);
      res.is_empty = (stored_count == 0);
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly legal positions up to span, sometimes zero or past the end
   function automatic logic [7:0] random_position(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 8'd0;
      if (r < 18 || span < 1) return 8'($urandom_range(span + 1, 255));
      return 8'($urandom_range(1, span));
   endfunction

   // ------------------------------------------------------------------------
   // request side: optional idle, then hold the request until it is taken
   // ------------------------------------------------------------------------
   task automatic send_request(logic [2:0] cmd, logic [7:0] pos, logic [7:0] val);
      int gap;
      gap = sender_idle ? random_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, val, pos, cmd};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_list_command(cmd, pos, val));
   endtask

   // one random command; growing favors insert/append, otherwise delete
   task automatic send_random_request(bit growing);
      int         r;
      logic [2:0] cmd;
      logic [7:0] pos;
      logic [7:0] val;
      r = $urandom_range(0, 99);
      if (growing) begin
         if (r < 25)      cmd = CMD_APPEND;
         else if (r < 55) cmd = CMD_INSERT;
         else if (r < 65) cmd = CMD_DELETE;
         else if (r < 77) cmd = CMD_READ;
         else if (r < 94) cmd = CMD_LOCATE;
         else if (r < 95) cmd = CMD_CLEAR;
         else if (r < 97) cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LOW : CMD_SPARE_HIGH;
         else             cmd = CMD_INSERT;
      end else begin
         if (r < 10)      cmd = CMD_APPEND;
         else if (r < 25) cmd = CMD_INSERT;
         else if (r < 60) cmd = CMD_DELETE;
         else if (r < 75) cmd = CMD_READ;
         else if (r < 94) cmd = CMD_LOCATE;
         else if (r < 95) cmd = CMD_CLEAR;
         else if (r < 97) cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LOW : CMD_SPARE_HIGH;
         else             cmd = CMD_READ;
      end
      // small value pool makes locate hit and finds duplicates
      val = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      if (cmd == CMD_LOCATE && stored_count > 0 && $urandom_range(0, 99) < 60)
         val = stored_bytes[$urandom_range(0, stored_count - 1)];
      if (cmd == CMD_INSERT)
         pos = random_position(stored_count + 1);
      else if (cmd == CMD_DELETE || cmd == CMD_READ)
         pos = random_position(stored_count);
      else
         pos = 8'($urandom_range(0, 255));
      send_request(cmd, pos, val);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls, plus a long hold-off counted here
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else if (receiver_stall > 0) begin
         rsp_tready <= 1'b0;
         receiver_stall--;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
         receiver_gap = random_gap();
         rsp_tready <= (receiver_gap == 0);
         if (receiver_gap > 0)
            receiver_stall = receiver_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $realtime, field, want, got);
      end
   endtask

   // each accepted response against the oldest pending one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t ns: response %h with nothing pending", $realtime, rsp_tdata);
         end else begin
            want_result = pending_results.pop_front();
            got_result  = list_result_t'(rsp_tdata[27:0]);
            check_field("status",   want_result.status,   got_result.status);
            check_field("element",  want_result.element,  got_result.element);
            check_field("found_at", want_result.found_at, got_result.found_at);
            check_field("length",   want_result.length,   got_result.length);
            check_field("is_empty", want_result.is_empty, got_result.is_empty);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // corner cases: empty list, position bounds, full list, spare codes
   task automatic test_directed();
      send_request(CMD_CLEAR,  8'd0,   8'd0);     // clear of an empty list
      send_request(CMD_READ,   8'd1,   8'd0);     // read from an empty list
      send_request(CMD_DELETE, 8'd1,   8'd0);     // delete from an empty list
      send_request(CMD_LOCATE, 8'd0,   8'd0);     // empty list never matches
      send_request(CMD_INSERT, 8'd0,   8'h11);    // position zero
      send_request(CMD_INSERT, 8'd2,   8'h22);    // past count+1
      send_request(CMD_INSERT, 8'd1,   8'h00);    // first element by insert
      send_request(CMD_APPEND, 8'd0,   8'hFF);
      send_request(CMD_INSERT, 8'd3,   8'h5A);    // insert at count+1 is a tail add
      send_request(CMD_INSERT, 8'd2,   8'hA5);    // middle insert becomes element 2
      send_request(CMD_READ,   8'd255, 8'd0);
      send_request(CMD_DELETE, 8'd0,   8'd0);
      send_request(CMD_LOCATE, 8'd0,   8'hFF);
      send_request(CMD_LOCATE, 8'd255, 8'h77);    // no match
      send_request(CMD_SPARE_LOW,  8'd1, 8'h01);
      send_request(CMD_SPARE_HIGH, 8'd255, 8'hFF);
      while (stored_count < LIST_CAPACITY)
         send_request(CMD_APPEND, 8'd0, 8'($urandom_range(0, 255)));
      send_request(CMD_APPEND, 8'd0,   8'h33);    // append to a full list
      send_request(CMD_INSERT, 8'(LIST_CAPACITY + 1), 8'h44); // valid slot, but full
      send_request(CMD_INSERT, 8'(LIST_CAPACITY + 2), 8'h44); // bad position wins
      send_request(CMD_DELETE, 8'(LIST_CAPACITY), 8'd0);      // last element
      send_request(CMD_DELETE, 8'd1,   8'd0);                 // first element
      send_request(CMD_READ,   8'(LIST_CAPACITY - 2), 8'd0);
      send_request(CMD_CLEAR,  8'd0,   8'd0);
   endtask

   // long random run, alternating growing and shrinking phases, idling on
   task automatic test_random_mix();
      int n;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      for (n = 0; n < 300; n++)
         send_random_request(((n / 40) % 2) == 0);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_response_hold_off();
      int n;
      sender_idle     = 1'b0;
      hold_off_cycles = 400;
      for (n = 0; n < 40; n++)
         send_random_request(1'b1);
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      int n;
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      for (n = 0; n < 80; n++)
         send_random_request((n / 20) % 2 == 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix();
      test_response_hold_off();
      test_back_to_back();

      @(negedge clock);
      req_tvalid <= 1'b0;
      receiver_idle = 1'b1;

      // let every pending response come back, then a few quiet cycles
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0)
         $display("positional_list_engine_test: done, clean");
      else
         $display("positional_list_engine_test: done, errors");
      $finish;
   end

   // run limit, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("positional_list_engine_test: done, errors");
      $finish;
   end

endmodule

FILE: positional_list_engine.f
rtl/ple_pkg.sv
rtl/positional_list_engine.sv
bench/positional_list_engine_test.sv
